// ===== src/ucs_to_utf8_transcoder_core_defines.svh =====
// assertion macros shared by the transcoder rtl
`ifndef UCS_TO_UTF8_TRANSCODER_CORE_DEFINES_SVH
`define UCS_TO_UTF8_TRANSCODER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define U2U8_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define U2U8_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/u2u8_pkg.sv =====
package u2u8_pkg;

    // field widths
    localparam int BYTE_W     = 8;
    localparam int CODE_W     = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;
    localparam int REST_W     = 30;
    localparam int REMAIN_W   = 3;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_FORMAT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_POLICY = 2'd2;

    // error policy bits
    localparam int POLICY_DISCARD = 0;
    localparam int POLICY_REPLACE = 1;

    // order mode bits
    localparam int ORDER_LITTLE = 0;
    localparam int ORDER_FIXED  = 1;

    // code point limits
    localparam logic [CODE_W-1:0] PLANE1_BASE  = 31'h0001_0000;
    localparam logic [CODE_W-1:0] REPL_CHAR    = 31'h0000_fffd;
    localparam logic [CODE_W-1:0] LIMIT_1BYTE  = 31'h0000_007f;
    localparam logic [CODE_W-1:0] LIMIT_2BYTE  = 31'h0000_07ff;
    localparam logic [CODE_W-1:0] LIMIT_3BYTE  = 31'h0000_ffff;
    localparam logic [CODE_W-1:0] LIMIT_4BYTE  = 31'h001f_ffff;
    localparam logic [CODE_W-1:0] LIMIT_5BYTE  = 31'h03ff_ffff;
    localparam logic [31:0]       UTF32_MAX    = 32'h0010_ffff;

    // byte order marks as received
    localparam logic [31:0] BOM_BIG        = 32'h0000_feff;
    localparam logic [31:0] BOM_LITTLE_W   = 32'hfffe_0000;
    localparam logic [31:0] BOM_LITTLE_N   = 32'h0000_fffe;
    localparam logic [31:0] NONCHAR_FFFE   = 32'h0000_fffe;
    localparam logic [31:0] NONCHAR_FFFF   = 32'h0000_ffff;

    // surrogate ranges seen by their upper bits
    localparam logic [20:0] SURR_TOP       = 21'h00_001b;
    localparam logic [21:0] SURR_HIGH_TOP  = 22'h00_0036;
    localparam logic [21:0] SURR_LOW_TOP   = 22'h00_0037;

    typedef enum logic [1:0] {
        FMT_UCS2  = 2'd0,
        FMT_UTF16 = 2'd1,
        FMT_UTF32 = 2'd2,
        FMT_UCS4  = 2'd3
    } unit_format_t;

    typedef enum logic [1:0] {
        ST_CONVERTED  = 2'd0,
        ST_REPLACED   = 2'd1,
        ST_ILLEGAL    = 2'd2,
        ST_INCOMPLETE = 2'd3
    } status_t;

    // one classified unit waiting for serialization
    typedef struct packed {
        logic [CODE_W-1:0] code;
        status_t           status;
    } job_t;

endpackage

// ===== src/ucs_to_utf8_transcoder_core.sv =====
// channel   direction  handshake              payload
// s_        in         s_valid / s_ready      s_action, s_in_byte, s_stream_end
// m_        out        m_valid / m_ready      m_out_byte, m_status, m_last_of_run
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one input byte is taken per cycle while the unit queue has room
// each request produces 0 to 6 result bytes; the serializer sends one byte per cycle while m_ready is high
// the first result byte passes through the queue, the job register and the output register
// synchronous active-low reset empties the queue and serializer, registers to defaults
// a stalled result side fills the queue, then s_ready drops; cfg_ready is always high
module ucs_to_utf8_transcoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic [u2u8_pkg::BYTE_W-1:0]       s_in_byte,
    input  logic                              s_stream_end,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [u2u8_pkg::BYTE_W-1:0]       m_out_byte,
    output logic [1:0]                        m_status,
    output logic                              m_last_of_run,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [u2u8_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [u2u8_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import u2u8_pkg::*;

    logic  accept;
    logic  job_push;
    job_t  push_job;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;
    job_t  q_job;

    // input side handshake
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // assembly, byte order and validity checks
    u2u8_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_write  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .action     (s_action),
        .in_byte    (s_in_byte),
        .stream_end (s_stream_end),
        .job_push   (job_push),
        .job        (push_job)
    );

    // classified units between front and serializer
    u2u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_job)
    );

    // utf-8 serializer and output register
    u2u8_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_job         (q_job),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_status      (m_status),
        .m_last_of_run (m_last_of_run)
    );

endmodule

// ===== src/u2u8_queue.sv =====
`include "ucs_to_utf8_transcoder_core_defines.svh"

module u2u8_queue #(
    parameter int DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  u2u8_pkg::job_t  push_data,
    output logic            full,
    input  logic            pop,
    output logic            pop_valid,
    output u2u8_pkg::job_t  pop_data
);
    import u2u8_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // status toward both sides
    assign full      = (count_reg == FULL_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entries_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    `U2U8_ASSERT_IMP(a_no_pop_empty, aclk, aresetn, pop, count_reg != '0, "pop from empty queue")
    `U2U8_ASSERT_IMP(a_no_push_full, aclk, aresetn, push, count_reg != FULL_CNT, "push into full queue")
    `U2U8_ASSERT_NXT(a_count_grows, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1, "fill count did not grow")

endmodule

// ===== src/u2u8_front.sv =====
module u2u8_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_write,
    input  logic [u2u8_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [u2u8_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               accept,
    input  logic                               action,
    input  logic [u2u8_pkg::BYTE_W-1:0]        in_byte,
    input  logic                               stream_end,
    output logic                               job_push,
    output u2u8_pkg::job_t                     job
);
    import u2u8_pkg::*;

    unit_format_t            unit_format_reg, unit_format_next;
    logic [CFG_DATA_W-1:0]   order_mode_reg, order_mode_next;
    logic [CFG_DATA_W-1:0]   error_policy_reg, error_policy_next;
    logic [23:0]             accum_reg, accum_next;
    logic [1:0]              byte_count_reg, byte_count_next;
    logic [9:0]              high_half_reg, high_half_next;
    logic                    have_high_reg, have_high_next;
    logic                    bom_checked_reg, bom_checked_next;
    logic                    little_reg, little_next;

    logic                    wide;
    logic                    unit_done;
    logic [31:0]             raw;
    logic [31:0]             swapped;
    logic [31:0]             u;
    logic [31:0]             bom_little;
    logic                    bom_hit;
    logic                    is_nonchar;
    logic                    is_sur;
    logic                    is_high;
    logic                    is_low;
    logic [CODE_W-1:0]       pair_code;
    logic                    unit_illegal;
    logic                    unit_valid;
    logic [CODE_W-1:0]       unit_code;
    logic                    incomplete;

    // unit assembly and byte order
    always_comb begin
        wide       = (unit_format_reg == FMT_UTF32) || (unit_format_reg == FMT_UCS4);
        unit_done  = wide ? (byte_count_reg == 2'd3) : (byte_count_reg != 2'd0);
        raw        = wide ? {accum_reg, in_byte} : {16'h0000, accum_reg[7:0], in_byte};
        swapped    = wide ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]}
                          : {16'h0000, raw[7:0], raw[15:8]};
        u          = little_reg ? swapped : raw;
        bom_little = wide ? BOM_LITTLE_W : BOM_LITTLE_N;
        bom_hit    = !bom_checked_reg && ((raw == BOM_BIG) || (raw == bom_little));
        is_nonchar = (u == NONCHAR_FFFE) || (u == NONCHAR_FFFF);
        is_sur     = (u[31:11] == SURR_TOP);
        is_high    = (u[31:10] == SURR_HIGH_TOP);
        is_low     = (u[31:10] == SURR_LOW_TOP);
        pair_code  = CODE_W'({high_half_reg, u[9:0]}) + PLANE1_BASE;
    end

    // state update and classification
    always_comb begin
        unit_format_next  = unit_format_reg;
        order_mode_next   = order_mode_reg;
        error_policy_next = error_policy_reg;
        accum_next        = accum_reg;
        byte_count_next   = byte_count_reg;
        high_half_next    = high_half_reg;
        have_high_next    = have_high_reg;
        bom_checked_next  = bom_checked_reg;
        little_next       = little_reg;
        unit_illegal      = 1'b0;
        unit_valid        = 1'b0;
        unit_code         = u[CODE_W-1:0];
        incomplete        = 1'b0;

        if (accept) begin
            if (action) begin
                // restart: drop partial unit, reload byte order
                accum_next       = '0;
                byte_count_next  = '0;
                high_half_next   = '0;
                have_high_next   = 1'b0;
                little_next      = order_mode_reg[ORDER_LITTLE];
                bom_checked_next = order_mode_reg[ORDER_FIXED];
            end else begin
                if (unit_done) begin
                    accum_next       = '0;
                    byte_count_next  = '0;
                    bom_checked_next = 1'b1;
                    if (bom_hit) begin
                        little_next = (raw == bom_little);
                    end else begin
                        case (unit_format_reg)
                            FMT_UCS2: begin
                                if (is_nonchar || is_sur) begin
                                    unit_illegal = 1'b1;
                                end else begin
                                    unit_valid = 1'b1;
                                end
                            end
                            FMT_UTF16: begin
                                if (have_high_reg) begin
                                    have_high_next = 1'b0;
                                    high_half_next = '0;
                                    if (is_low) begin
                                        unit_valid = 1'b1;
                                        unit_code  = pair_code;
                                    end else begin
                                        unit_illegal = 1'b1;
                                    end
                                end else if (is_low || is_nonchar) begin
                                    unit_illegal = 1'b1;
                                end else if (is_high) begin
                                    high_half_next = u[9:0];
                                    have_high_next = 1'b1;
                                end else begin
                                    unit_valid = 1'b1;
                                end
                            end
                            FMT_UTF32: begin
                                if (is_nonchar || is_sur || (u > UTF32_MAX)) begin
                                    unit_illegal = 1'b1;
                                end else begin
                                    unit_valid = 1'b1;
                                end
                            end
                            default: begin
                                if (is_nonchar || is_sur || u[31]) begin
                                    unit_illegal = 1'b1;
                                end else begin
                                    unit_valid = 1'b1;
                                end
                            end
                        endcase
                    end
                end else begin
                    accum_next      = {accum_reg[15:0], in_byte};
                    byte_count_next = byte_count_reg + 1'b1;
                end

                // stream end with a partial unit or pending high surrogate
                if (stream_end && ((byte_count_next != 2'd0) || have_high_next)) begin
                    accum_next      = '0;
                    byte_count_next = '0;
                    high_half_next  = '0;
                    have_high_next  = 1'b0;
                    incomplete      = 1'b1;
                end
            end
        end

        // register writes
        if (cfg_write) begin
            case (cfg_index)
                REG_UNIT_FORMAT: begin
                    unit_format_next = unit_format_t'(cfg_data);
                    accum_next       = '0;
                    byte_count_next  = '0;
                    high_half_next   = '0;
                    have_high_next   = 1'b0;
                end
                REG_ORDER_MODE: begin
                    order_mode_next  = cfg_data;
                    accum_next       = '0;
                    byte_count_next  = '0;
                    high_half_next   = '0;
                    have_high_next   = 1'b0;
                    little_next      = cfg_data[ORDER_LITTLE];
                    bom_checked_next = cfg_data[ORDER_FIXED];
                end
                REG_ERROR_POLICY: begin
                    error_policy_next = cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // job toward the queue
    always_comb begin
        job_push   = incomplete || unit_valid ||
                     (unit_illegal && !error_policy_reg[POLICY_DISCARD]);
        job.code   = unit_code;
        job.status = ST_CONVERTED;
        if (incomplete || unit_illegal) begin
            if (error_policy_reg[POLICY_REPLACE]) begin
                job.code   = REPL_CHAR;
                job.status = ST_REPLACED;
            end else begin
                job.code   = '0;
                job.status = incomplete ? ST_INCOMPLETE : ST_ILLEGAL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_format_reg  <= FMT_UTF16;
            order_mode_reg   <= '0;
            error_policy_reg <= '0;
            accum_reg        <= '0;
            byte_count_reg   <= '0;
            high_half_reg    <= '0;
            have_high_reg    <= 1'b0;
            bom_checked_reg  <= 1'b0;
            little_reg       <= 1'b0;
        end else begin
            unit_format_reg  <= unit_format_next;
            order_mode_reg   <= order_mode_next;
            error_policy_reg <= error_policy_next;
            accum_reg        <= accum_next;
            byte_count_reg   <= byte_count_next;
            high_half_reg    <= high_half_next;
            have_high_reg    <= have_high_next;
            bom_checked_reg  <= bom_checked_next;
            little_reg       <= little_next;
        end
    end

endmodule

// ===== src/u2u8_back.sv =====
`include "ucs_to_utf8_transcoder_core_defines.svh"

module u2u8_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  u2u8_pkg::job_t                q_job,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [u2u8_pkg::BYTE_W-1:0]   m_out_byte,
    output logic [1:0]                    m_status,
    output logic                          m_last_of_run
);
    import u2u8_pkg::*;

    logic                  job_valid_reg, job_valid_next;
    logic [BYTE_W-1:0]     job_byte_reg, job_byte_next;
    logic [REST_W-1:0]     rest_reg, rest_next;
    logic [REMAIN_W-1:0]   remain_reg, remain_next;
    status_t               job_status_reg, job_status_next;

    logic                  m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]     m_byte_reg, m_byte_next;
    status_t               m_status_reg, m_status_next;
    logic                  m_last_reg, m_last_next;

    logic                  out_load;
    logic                  job_done;
    logic [BYTE_W-1:0]     lead_byte;
    logic [REST_W-1:0]     lead_rest;
    logic [REMAIN_W-1:0]   lead_remain;
    logic [CODE_W-1:0]     c;

    // lead byte and trailing groups of the job at the queue head
    always_comb begin
        c = q_job.code;
        if ((q_job.status == ST_ILLEGAL) || (q_job.status == ST_INCOMPLETE)) begin
            lead_byte   = '0;
            lead_rest   = '0;
            lead_remain = 3'd0;
        end else if (c <= LIMIT_1BYTE) begin
            lead_byte   = c[7:0];
            lead_rest   = '0;
            lead_remain = 3'd0;
        end else if (c <= LIMIT_2BYTE) begin
            lead_byte   = {3'b110, c[10:6]};
            lead_rest   = {c[5:0], 24'h000000};
            lead_remain = 3'd1;
        end else if (c <= LIMIT_3BYTE) begin
            lead_byte   = {4'b1110, c[15:12]};
            lead_rest   = {c[11:0], 18'h00000};
            lead_remain = 3'd2;
        end else if (c <= LIMIT_4BYTE) begin
            lead_byte   = {5'b11110, c[20:18]};
            lead_rest   = {c[17:0], 12'h000};
            lead_remain = 3'd3;
        end else if (c <= LIMIT_5BYTE) begin
            lead_byte   = {6'b111110, c[25:24]};
            lead_rest   = {c[23:0], 6'h00};
            lead_remain = 3'd4;
        end else begin
            lead_byte   = {7'b1111110, c[30]};
            lead_rest   = c[29:0];
            lead_remain = 3'd5;
        end
    end

    // handshake between job register, output register and queue
    assign out_load = job_valid_reg && (!m_valid_reg || m_ready);
    assign job_done = out_load && (remain_reg == '0);
    assign q_pop    = q_valid && (!job_valid_reg || job_done);

    // serializer and output register
    always_comb begin
        job_valid_next  = job_valid_reg;
        job_byte_next   = job_byte_reg;
        rest_next       = rest_reg;
        remain_next     = remain_reg;
        job_status_next = job_status_reg;
        m_valid_next    = m_valid_reg;
        m_byte_next     = m_byte_reg;
        m_status_next   = m_status_reg;
        m_last_next     = m_last_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next  = 1'b1;
            m_byte_next   = job_byte_reg;
            m_status_next = job_status_reg;
            m_last_next   = (remain_reg == '0);
            if (remain_reg != '0) begin
                job_byte_next = {2'b10, rest_reg[REST_W-1 -: 6]};
                rest_next     = {rest_reg[REST_W-7:0], 6'h00};
                remain_next   = remain_reg - 1'b1;
            end else begin
                job_valid_next = 1'b0;
            end
        end
        if (q_pop) begin
            job_valid_next  = 1'b1;
            job_byte_next   = lead_byte;
            rest_next       = lead_rest;
            remain_next     = lead_remain;
            job_status_next = q_job.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            remain_reg    <= '0;
        end else begin
            job_valid_reg <= job_valid_next;
            m_valid_reg   <= m_valid_next;
            remain_reg    <= remain_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_byte_reg   <= job_byte_next;
        rest_reg       <= rest_next;
        job_status_reg <= job_status_next;
        m_byte_reg     <= m_byte_next;
        m_status_reg   <= m_status_next;
        m_last_reg     <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_byte_reg;
    assign m_status      = m_status_reg;
    assign m_last_of_run = m_last_reg;

    `U2U8_ASSERT_NXT(a_pop_loads_job, aclk, aresetn, q_pop, job_valid_reg, "popped job not loaded")
    `U2U8_ASSERT_IMP(a_error_single, aclk, aresetn, job_valid_reg && ((job_status_reg == ST_ILLEGAL) || (job_status_reg == ST_INCOMPLETE)), remain_reg == '0, "error job longer than one byte")
    `U2U8_ASSERT_IMP(a_error_out, aclk, aresetn, m_valid_reg && ((m_status_reg == ST_ILLEGAL) || (m_status_reg == ST_INCOMPLETE)), m_last_reg && (m_byte_reg == '0), "error result malformed")

endmodule

// ===== verif/tb.sv =====
import u2u8_pkg::*;

// one utf-8 byte as the block should send it
typedef struct {
    logic [7:0] data;
    status_t    st;
    logic       last;
} utf8_byte_t;

// tracks the transcoder state and the utf-8 bytes still owed by the block
class utf8_tracker;
    unit_format_t fmt;
    logic [1:0]   order;
    logic [1:0]   policy;
    logic [31:0]  accum;
    int unsigned  nbytes;
    logic [15:0]  high_half;
    bit           have_high;
    bit           bom_done;
    bit           little;
    utf8_byte_t   utf8_due[$];
    utf8_byte_t   burst[$];
    int           mismatches;

    function new();
        fmt = FMT_UTF16;
        order = 2'd0;
        policy = 2'd0;
        mismatches = 0;
        drop_partial();
        restart_order();
    endfunction

    function void drop_partial();
        accum = '0;
        nbytes = 0;
        high_half = '0;
        have_high = 1'b0;
    endfunction

    function void restart_order();
        little = order[ORDER_LITTLE];
        bom_done = order[ORDER_FIXED];
    endfunction

    function int pending();
        return utf8_due.size();
    endfunction

    function void emit(input logic [7:0] d, input status_t st);
        utf8_byte_t r;
        if (burst.size() < 6) begin
            r.data = d;
            r.st = st;
            r.last = 1'b0;
            burst.push_back(r);
        end
    endfunction

    function void emit_replacement();
        emit(8'hef, ST_REPLACED);
        emit(8'hbf, ST_REPLACED);
        emit(8'hbd, ST_REPLACED);
    endfunction

    function void on_illegal();
        if (policy[POLICY_DISCARD])
            return;
        if (policy[POLICY_REPLACE])
            emit_replacement();
        else
            emit(8'h00, ST_ILLEGAL);
    endfunction

    function void on_incomplete();
        if (policy[POLICY_REPLACE])
            emit_replacement();
        else
            emit(8'h00, ST_INCOMPLETE);
    endfunction

    // utf-8 encoding of up to 31 bits
    function void encode(input logic [31:0] u);
        if (u <= 32'h7f) begin
            emit(u[7:0], ST_CONVERTED);
        end else if (u <= 32'h7ff) begin
            emit({3'b110, u[10:6]}, ST_CONVERTED);
            emit({2'b10, u[5:0]}, ST_CONVERTED);
        end else if (u <= 32'hffff) begin
            emit({4'b1110, u[15:12]}, ST_CONVERTED);
            emit({2'b10, u[11:6]}, ST_CONVERTED);
            emit({2'b10, u[5:0]}, ST_CONVERTED);
        end else if (u <= 32'h1fffff) begin
            emit({5'b11110, u[20:18]}, ST_CONVERTED);
            emit({2'b10, u[17:12]}, ST_CONVERTED);
            emit({2'b10, u[11:6]}, ST_CONVERTED);
            emit({2'b10, u[5:0]}, ST_CONVERTED);
        end else if (u <= 32'h3ffffff) begin
            emit({6'b111110, u[25:24]}, ST_CONVERTED);
            emit({2'b10, u[23:18]}, ST_CONVERTED);
            emit({2'b10, u[17:12]}, ST_CONVERTED);
            emit({2'b10, u[11:6]}, ST_CONVERTED);
            emit({2'b10, u[5:0]}, ST_CONVERTED);
        end else begin
            emit({7'b1111110, u[30]}, ST_CONVERTED);
            emit({2'b10, u[29:24]}, ST_CONVERTED);
            emit({2'b10, u[23:18]}, ST_CONVERTED);
            emit({2'b10, u[17:12]}, ST_CONVERTED);
            emit({2'b10, u[11:6]}, ST_CONVERTED);
            emit({2'b10, u[5:0]}, ST_CONVERTED);
        end
    endfunction

    // one complete unit: bom check, byte swap, format rules
    function void take_unit(input logic [31:0] raw, input bit wide);
        logic [31:0] u;
        bit          is_surr;
        bit          is_low;
        if (!bom_done) begin
            bom_done = 1'b1;
            if (raw == 32'h0000feff) begin
                little = 1'b0;
                return;
            end
            if (raw == (wide ? 32'hfffe0000 : 32'h0000fffe)) begin
                little = 1'b1;
                return;
            end
        end
        if (!little)
            u = raw;
        else if (wide)
            u = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
        else
            u = {16'h0, raw[7:0], raw[15:8]};
        is_surr = (u >= 32'hd800) && (u <= 32'hdfff);
        is_low = (u >= 32'hdc00) && (u <= 32'hdfff);

        case (fmt)
            FMT_UCS2: begin
                if (u >= 32'hfffe || is_surr)
                    on_illegal();
                else
                    encode(u);
            end
            FMT_UTF16: begin
                if (have_high) begin
                    have_high = 1'b0;
                    if (is_low)
                        encode(((({16'h0, high_half} - 32'hd800) << 10) |
                                (u - 32'hdc00)) + 32'h10000);
                    else
                        on_illegal();
                    high_half = '0;
                end else if (is_low || u >= 32'hfffe) begin
                    on_illegal();
                end else if (u >= 32'hd800 && u <= 32'hdbff) begin
                    high_half = u[15:0];
                    have_high = 1'b1;
                end else begin
                    encode(u);
                end
            end
            FMT_UTF32: begin
                if (u == 32'hfffe || u == 32'hffff || u > 32'h10ffff || is_surr)
                    on_illegal();
                else
                    encode(u);
            end
            default: begin
                if (u == 32'hfffe || u == 32'hffff || u > 32'h7fffffff || is_surr)
                    on_illegal();
                else
                    encode(u);
            end
        endcase
    endfunction

    function void write_register(input logic [1:0] idx, input logic [1:0] val);
        case (idx)
            REG_UNIT_FORMAT: begin
                fmt = unit_format_t'(val);
                drop_partial();
            end
            REG_ORDER_MODE: begin
                order = val;
                drop_partial();
                restart_order();
            end
            REG_ERROR_POLICY: policy = val;
            default: ;
        endcase
    endfunction

    // accepted input request: queue up the bytes it should produce
    function void take_request(input logic act, input logic [7:0] b, input logic fin);
        bit          wide;
        int unsigned size;
        logic [31:0] raw;
        burst.delete();
        if (act) begin
            drop_partial();
            restart_order();
            return;
        end
        wide = fmt[1];
        size = wide ? 4 : 2;
        accum = {accum[23:0], b};
        nbytes++;
        if (nbytes >= size) begin
            raw = wide ? accum : {16'h0, accum[15:0]};
            accum = '0;
            nbytes = 0;
            take_unit(raw, wide);
        end
        if (fin && (nbytes != 0 || have_high)) begin
            drop_partial();
            on_incomplete();
        end
        if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i])
            utf8_due.push_back(burst[i]);
    endfunction

    // accepted result byte against the oldest owed byte
    function void match_byte(input logic [7:0] b, input logic [1:0] st, input logic last);
        utf8_byte_t want;
        if (utf8_due.size() == 0) begin
            $display("%0t: unexpected result out_byte %h status %0d last %0d",
                     $time, b, st, last);
            mismatches++;
            return;
        end
        want = utf8_due.pop_front();
        if (b !== want.data) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.data, b);
            mismatches++;
        end
        if (st !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, st);
            mismatches++;
        end
        if (last !== want.last) begin
            $display("%0t: last_of_run expected %0d actual %0d", $time, want.last, last);
            mismatches++;
        end
    endfunction
endclass

module tb;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD = 80;
    localparam int SETTLE_CYCLES = 12;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic       s_action;
    logic [7:0] s_in_byte;
    logic       s_stream_end;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic [1:0] m_status;
    logic       m_last_of_run;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [1:0] cfg_data;

    utf8_tracker sb;
    bit          idle_on;
    bit          hold_req;
    int          bytes_sent;
    int          quiet_cycles;

    ucs_to_utf8_transcoder_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_in_byte     (s_in_byte),
        .s_stream_end  (s_stream_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_status      (m_status),
        .m_last_of_run (m_last_of_run),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // result side: random stall bursts and one long hold on request
    initial begin
        int stall;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                stall = LONG_HOLD;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 4);
            end else begin
                stall = 0;
            end
            m_ready <= (stall == 0);
            repeat ((stall > 0) ? stall : 1) @(posedge aclk);
        end
    end

    // monitor, scoreboard hookup and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.write_register(cfg_index, cfg_data);
            if (s_valid && s_ready)
                sb.take_request(s_action, s_in_byte, s_stream_end);
            if (m_valid && m_ready)
                sb.match_byte(m_out_byte, m_status, m_last_of_run);
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("tb: errors");
                    $finish;
                end
            end
        end
    end

    task automatic send_byte(input logic act, input logic [7:0] b, input logic fin);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_in_byte <= b;
        s_stream_end <= fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    // one unit, byte order as it goes on the wire
    task automatic send_unit(input logic [31:0] v, input bit wide, input bit lit,
                             input bit fin);
        int         n;
        logic [7:0] b;
        n = wide ? 4 : 2;
        for (int k = 0; k < n; k++) begin
            b = lit ? v[8*k +: 8] : v[8*(n-1-k) +: 8];
            send_byte(1'b0, b, fin && (k == n - 1));
        end
    endtask

    task automatic send_seq(input logic [7:0] seq[$], input bit fin_last);
        foreach (seq[i])
            send_byte(1'b0, seq[i], fin_last && (i == seq.size() - 1));
    endtask

    task automatic write_settings(input logic [1:0] f, input logic [1:0] o,
                                  input logic [1:0] p);
        logic [1:0] vals[3];
        logic [1:0] regs[3];
        vals = '{f, o, p};
        regs = '{REG_UNIT_FORMAT, REG_ORDER_MODE, REG_ERROR_POLICY};
        for (int k = 0; k < 3; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data <= vals[k];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    // stop offering input until every owed byte is out, then idle a while
    task automatic drain(input int extra);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    // random code point spread over the utf-8 lengths, clamped to the format
    function automatic logic [31:0] rand_code(input int maxlen, input logic [31:0] top);
        logic [31:0] c;
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 10))
                0: c = 32'h0;
                1: c = 32'h7f;
                2: c = 32'h80;
                3: c = 32'h7ff;
                4: c = 32'h800;
                5: c = 32'hd7ff;
                6: c = 32'he000;
                7: c = 32'hfffd;
                8: c = 32'h10ffff;
                9: c = 32'h3ffffff;
                default: c = 32'h7fffffff;
            endcase
        end else begin
            case ($urandom_range(1, maxlen))
                1: c = 32'($urandom_range(0, 32'h7f));
                2: c = 32'($urandom_range(32'h80, 32'h7ff));
                3: c = $urandom_range(0, 1) ? 32'($urandom_range(32'h800, 32'hd7ff))
                                            : 32'($urandom_range(32'he000, 32'hfffd));
                4: c = 32'($urandom_range(32'h10000, 32'h1fffff));
                5: c = 32'($urandom_range(32'h200000, 32'h3ffffff));
                default: c = 32'($urandom_range(32'h4000000, 32'h7fffffff));
            endcase
        end
        if (c > top)
            c = top;
        return c;
    endfunction

    // well-formed character in the current format and order
    task automatic send_char(input logic [1:0] f, input bit lit, input bit fin);
        logic [31:0] c;
        logic [31:0] w;
        case (f)
            FMT_UCS2: send_unit(rand_code(3, 32'hfffd), 1'b0, lit, fin);
            FMT_UTF16: begin
                c = rand_code(4, 32'h10ffff);
                if (c >= 32'h10000) begin
                    w = c - 32'h10000;
                    send_unit({16'h0, 6'b110110, w[19:10]}, 1'b0, lit, 1'b0);
                    send_unit({16'h0, 6'b110111, w[9:0]}, 1'b0, lit, fin);
                end else begin
                    send_unit(c, 1'b0, lit, fin);
                end
            end
            FMT_UTF32: send_unit(rand_code(4, 32'h10ffff), 1'b1, lit, fin);
            default: send_unit(rand_code(6, 32'h7fffffff), 1'b1, lit, fin);
        endcase
    endtask

    // a unit the format rejects
    task automatic send_illegal(input logic [1:0] f, input bit lit);
        logic [31:0] v;
        int          pick;
        pick = $urandom_range(0, 2);
        if (pick == 0)
            v = 32'($urandom_range(32'hdc00, 32'hdfff));
        else
            v = 32'hfffe | 32'($urandom_range(0, 1));
        case (f)
            FMT_UCS2: begin
                if (pick == 2)
                    v = 32'($urandom_range(32'hd800, 32'hdbff));
                send_unit(v, 1'b0, lit, 1'b0);
            end
            FMT_UTF16: begin
                if (pick == 2) begin
                    // high surrogate followed by a plain character
                    send_unit(32'($urandom_range(32'hd800, 32'hdbff)), 1'b0, lit, 1'b0);
                    send_unit(32'($urandom_range(0, 32'hd7ff)), 1'b0, lit, 1'b0);
                end else begin
                    send_unit(v, 1'b0, lit, 1'b0);
                end
            end
            FMT_UTF32: begin
                if (pick == 2)
                    v = 32'($urandom_range(32'h110000, 32'hffffffff));
                send_unit(v, 1'b1, lit, 1'b0);
            end
            default: begin
                if (pick == 2)
                    v = 32'h80000000 | 32'($urandom);
                send_unit(v, 1'b1, lit, 1'b0);
            end
        endcase
    endtask

    // stream ends in the middle of a unit or after a lone high surrogate
    task automatic send_partial(input logic [1:0] f, input bit lit);
        int n;
        if (f == FMT_UTF16 && $urandom_range(0, 1) == 1) begin
            send_unit(32'($urandom_range(32'hd800, 32'hdbff)), 1'b0, lit, 1'b1);
        end else begin
            n = f[1] ? $urandom_range(1, 3) : 1;
            for (int k = 0; k < n; k++)
                send_byte(1'b0, 8'($urandom_range(0, 255)), k == n - 1);
        end
    endtask

    initial begin
        logic [1:0] f;
        logic [1:0] o;
        logic [1:0] p;
        bit         lit;
        bit         paused;
        int         target;
        int         kind;

        sb = new();
        idle_on = 1'b1;
        hold_req = 1'b0;
        bytes_sent = 0;
        quiet_cycles = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_action <= 1'b0;
        s_in_byte <= 8'h00;
        s_stream_end <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_UNIT_FORMAT;
        cfg_data <= 2'd0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: utf-16, bom detect, report errors
        // bom, ascii, two-byte top, surrogate pair, highest plane
        send_seq('{8'hfe, 8'hff, 8'h00, 8'h41, 8'h07, 8'hff,
                   8'hd8, 8'h3d, 8'hde, 8'h00, 8'hdb, 8'hff, 8'hdf, 8'hff}, 1'b0);
        // lone low surrogate, then high surrogate without its low half
        send_seq('{8'hdc, 8'h00, 8'hd8, 8'h00, 8'h00, 8'h41}, 1'b0);
        // restart ignores its payload, then a stream cut after one byte
        send_byte(1'b1, 8'hff, 1'b1);
        send_byte(1'b0, 8'h12, 1'b1);
        // ucs-4 fixed little endian with replacement: six-byte maximum, too large
        drain(SETTLE_CYCLES);
        write_settings(FMT_UCS4, 2'd3, 2'd2);
        send_seq('{8'hff, 8'hff, 8'hff, 8'h7f, 8'h00, 8'h00, 8'h00, 8'h80}, 1'b0);

        // random phases, first four cover every register value
        for (int ph = 0; ph < 8; ph++) begin
            if (ph < 4) begin
                f = 2'(ph);
                o = 2'(3 - ph);
                p = 2'(ph);
            end else begin
                f = 2'($urandom_range(0, 3));
                o = 2'($urandom_range(0, 3));
                p = 2'($urandom_range(0, 3));
            end
            drain(SETTLE_CYCLES);
            idle_on = (ph < 6);
            write_settings(f, o, p);
            lit = o[ORDER_LITTLE];
            if (!o[ORDER_FIXED] && $urandom_range(0, 2) != 0) begin
                lit = $urandom_range(0, 1);
                send_unit(lit ? (f[1] ? 32'hfffe0000 : 32'h0000fffe) : 32'h0000feff,
                          f[1], 1'b0, 1'b0);
            end
            if (ph == 1)
                hold_req = 1'b1;
            paused = 1'b0;
            // the long hold phase runs longer so the queue surely fills
            target = bytes_sent + ((ph == 1) ? 22 : 14);
            while (bytes_sent < target) begin
                if (ph == 3 && !paused && bytes_sent > target - 11) begin
                    paused = 1'b1;
                    drain(0);
                end
                kind = $urandom_range(0, 15);
                if (kind < 12) begin
                    send_char(f, lit, $urandom_range(0, 15) == 0);
                end else if (kind < 14) begin
                    send_illegal(f, lit);
                end else if (kind == 14) begin
                    send_partial(f, lit);
                end else if ($urandom_range(0, 1) == 1) begin
                    send_byte(1'b1, 8'($urandom_range(0, 255)), $urandom_range(0, 1));
                    lit = o[ORDER_LITTLE];
                end else begin
                    // stray byte that also closes the stream, which realigns units
                    send_byte(1'b0, 8'($urandom_range(0, 255)), 1'b1);
                end
            end
        end

        drain(20);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
